// File: hw/rtl/avrb_pkg.sv
// Shared types, constants and the colour-wheel function for the VU bar meter.
// No dependencies; imported by every module of the block.
package avrb_pkg;

    localparam int CFG_W = 12;
    localparam int FALL_W = 7;
    localparam int HGT_W = 7;
    localparam int IDX_W = 6;
    localparam int COL_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] BASELINE_RST = 12'd2048;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 12'd60;
    localparam logic [CFG_W-1:0] FULL_SCALE_RST = 12'd600;
    localparam logic [FALL_W-1:0] FALL_STEP_RST = 7'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASELINE   = 2'd0,
        CFG_THRESHOLD  = 2'd1,
        CFG_FULL_SCALE = 2'd2,
        CFG_FALL_STEP  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0]  baseline;
        logic [CFG_W-1:0]  threshold;
        logic [CFG_W-1:0]  full_scale;
        logic [FALL_W-1:0] fall_step;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
    } t_rgb;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_PREP,
        FS_DIV,
        FS_PUSH
    } t_front_state;

    function automatic t_rgb wheel(input logic [COL_W-1:0] pos);
        logic [COL_W-1:0] p;
        logic [COL_W-1:0] q;
        logic [COL_W+1:0] t;
        t_rgb             c;
        p = 8'd255 - pos;
        priority if (p < 8'd85) begin
            t = 10'(p) * 10'd3;
            c.red = 8'd255 - t[COL_W-1:0];
            c.green = '0;
            c.blue = t[COL_W-1:0];
        end else if (p < 8'd170) begin
            q = p - 8'd85;
            t = 10'(q) * 10'd3;
            c.red = '0;
            c.green = t[COL_W-1:0];
            c.blue = 8'd255 - t[COL_W-1:0];
        end else begin
            q = p - 8'd170;
            t = 10'(q) * 10'd3;
            c.red = t[COL_W-1:0];
            c.green = 8'd255 - t[COL_W-1:0];
            c.blue = '0;
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/avrb_front.sv
// Front end: takes a sample, smooths and gates it, divides to a lit count
// and updates the bar height. Depends on avrb_pkg.
module avrb_front #(
    parameter int LED_COUNT = 64,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [SAMPLE_BITS-1:0]    i_sample,
    input  avrb_pkg::t_cfg            i_cfg,
    input  avrb_pkg::t_q_stat         i_q_stat,
    output logic                      o_push,
    output logic [avrb_pkg::HGT_W-1:0] o_push_height
);
    import avrb_pkg::*;

    localparam int AW = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
    localparam int LW = $clog2(LED_COUNT + 1);
    localparam int DW = AW + LW;
    localparam int FW = CFG_W + LW;
    localparam int CW = (DW > FW) ? DW : FW;
    localparam int QB = $clog2(LED_COUNT);
    localparam int SW = (QB > 1) ? $clog2(QB) : 1;

    t_front_state r_state, n_state;
    logic [AW-1:0]    r_smooth;
    logic [CW-1:0]    r_rem;
    logic [CFG_W-1:0] r_fs;
    logic [QB-1:0]    r_quot;
    logic             r_clamp;
    logic [SW-1:0]    r_step;
    logic [HGT_W-1:0] r_height;

    logic             w_accept;
    logic [AW-1:0]    w_raw;
    logic [AW-1:0]    w_base;
    logic [AW-1:0]    w_amp;
    logic [AW+1:0]    w_sum;
    logic [AW-1:0]    w_thr;
    logic [AW-1:0]    w_level;
    logic [CW-1:0]    w_div;
    logic [CFG_W-1:0] w_fs;
    logic [CW-1:0]    w_top;
    logic [CW-1:0]    w_trial;
    logic             w_ge;
    logic [HGT_W-1:0] w_lit;
    logic [HGT_W-1:0] w_next_height;

    assign w_accept = i_valid && (r_state == FS_IDLE);

    assign w_raw = AW'(i_sample);
    assign w_base = AW'(i_cfg.baseline);
    assign w_amp = (w_raw >= w_base) ? (w_raw - w_base) : (w_base - w_raw);
    assign w_sum = {1'b0, r_smooth, 1'b0} + (AW+2)'(r_smooth) + (AW+2)'(w_amp);

    assign w_thr = AW'(i_cfg.threshold);
    assign w_level = (r_smooth > w_thr) ? (r_smooth - w_thr) : '0;
    assign w_div = CW'(w_level) * CW'(LED_COUNT);
    assign w_fs = (i_cfg.full_scale == '0) ? CFG_W'(1) : i_cfg.full_scale;
    assign w_top = CW'(w_fs) * CW'(LED_COUNT);

    assign w_trial = CW'(r_fs) << r_step;
    assign w_ge = (r_rem >= w_trial);

    assign w_lit = r_clamp ? HGT_W'(LED_COUNT) : HGT_W'(r_quot);

    always_comb begin
        if (w_lit > r_height) begin
            w_next_height = w_lit;
        end else if (r_height > i_cfg.fall_step) begin
            w_next_height = r_height - i_cfg.fall_step;
        end else begin
            w_next_height = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: begin
                if (i_valid) begin
                    n_state = FS_PREP;
                end
            end
            FS_PREP: begin
                n_state = (w_div >= w_top) ? FS_PUSH : FS_DIV;
            end
            FS_DIV: begin
                if (r_step == '0) begin
                    n_state = FS_PUSH;
                end
            end
            FS_PUSH: begin
                if (!i_q_stat.full) begin
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != FS_IDLE);
        o_push = (r_state == FS_PUSH) && !i_q_stat.full;
        o_push_height = w_next_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_smooth <= '0;
            r_height <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_smooth <= w_sum[AW+1:2];
            end
            if (o_push) begin
                r_height <= w_next_height;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            FS_PREP: begin
                r_rem <= w_div;
                r_fs <= w_fs;
                r_clamp <= (w_div >= w_top);
                r_quot <= '0;
                r_step <= SW'(QB - 1);
            end
            FS_DIV: begin
                if (w_ge) begin
                    r_rem <= r_rem - w_trial;
                end
                r_quot <= (r_quot << 1) | QB'(w_ge);
                r_step <= r_step - SW'(1);
            end
            default: begin
            end
        endcase
    end

endmodule

// File: hw/rtl/avrb_queue.sv
// Two-entry queue of bar heights between front and back end.
// Depends on avrb_pkg.
module avrb_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [avrb_pkg::HGT_W-1:0] i_height,
    input  logic                       i_pop,
    output logic [avrb_pkg::HGT_W-1:0] o_head,
    output avrb_pkg::t_q_stat          o_stat
);
    import avrb_pkg::*;

    logic [HGT_W-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_height;
        end
    end

    assign o_head = r_mem[r_rd_ptr];
    assign o_stat.full = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

endmodule

// File: hw/rtl/avrb_back.sv
// Back end: walks one frame of LEDs per queued bar height and drives the
// registered result channel. Depends on avrb_pkg.
module avrb_back #(
    parameter int LED_COUNT = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  avrb_pkg::t_q_stat          i_q_stat,
    input  logic [avrb_pkg::HGT_W-1:0] i_height,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [avrb_pkg::IDX_W-1:0] o_led_index,
    output logic [avrb_pkg::COL_W-1:0] o_red,
    output logic [avrb_pkg::COL_W-1:0] o_green,
    output logic [avrb_pkg::COL_W-1:0] o_blue,
    output logic [avrb_pkg::HGT_W-1:0] o_bar_height,
    output logic                       o_last
);
    import avrb_pkg::*;

    localparam int QB = $clog2(LED_COUNT);

    logic [COL_W-1:0] w_pos [LED_COUNT];
    logic [QB-1:0]    r_idx;
    logic             r_valid;
    logic             w_load;
    logic             w_end;
    logic             w_lit;
    t_rgb             w_rgb;

    for (genvar g = 0; g < LED_COUNT; g++) begin : g_pos
        localparam int POS = (g * 255) / (LED_COUNT - 1);
        assign w_pos[g] = COL_W'(POS);
    end

    assign w_load = !i_q_stat.empty && (!r_valid || !i_stall);
    assign w_end = (r_idx == QB'(LED_COUNT - 1));
    assign w_lit = (HGT_W'(r_idx) < i_height);
    assign w_rgb = w_lit ? wheel(w_pos[r_idx]) : '0;
    assign o_pop = w_load && w_end;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx <= w_end ? '0 : r_idx + QB'(1);
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_led_index <= IDX_W'(r_idx);
            o_red <= w_rgb.red;
            o_green <= w_rgb.green;
            o_blue <= w_rgb.blue;
            o_bar_height <= i_height;
            o_last <= w_end;
        end
    end

endmodule

// File: hw/rtl/audio_vu_rainbow_bar_top.sv
// Audio VU rainbow bar meter. Each accepted sample gives one frame of
// LED_COUNT results, one per LED in index order, with last on the final LED.
// The front end does its smoothing and shift-subtract division for each
// sample, and a two-entry height queue lets it run ahead of the back end,
// which sends one LED per cycle from its output register while the receiver
// does not stall, so the back end's frame sets the sustained rate. Registers
// are to be written by the user through the cfg port (always ready) only
// while the block is idle; the block itself does not enforce this.
// Depends on avrb_pkg, avrb_front, avrb_queue and avrb_back.
module audio_vu_rainbow_bar_top #(
    parameter int LED_COUNT = 64,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [SAMPLE_BITS-1:0]         i_sample,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [avrb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [avrb_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [avrb_pkg::IDX_W-1:0]     o_led_index,
    output logic [avrb_pkg::COL_W-1:0]     o_red,
    output logic [avrb_pkg::COL_W-1:0]     o_green,
    output logic [avrb_pkg::COL_W-1:0]     o_blue,
    output logic [avrb_pkg::HGT_W-1:0]     o_bar_height,
    output logic                           o_last
);
    import avrb_pkg::*;

    t_cfg             r_cfg;
    t_q_stat          w_q_stat;
    logic             w_push;
    logic             w_pop;
    logic [HGT_W-1:0] w_push_height;
    logic [HGT_W-1:0] w_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.baseline <= BASELINE_RST;
            r_cfg.threshold <= THRESHOLD_RST;
            r_cfg.full_scale <= FULL_SCALE_RST;
            r_cfg.fall_step <= FALL_STEP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BASELINE:   r_cfg.baseline <= i_cfg_data;
                CFG_THRESHOLD:  r_cfg.threshold <= i_cfg_data;
                CFG_FULL_SCALE: r_cfg.full_scale <= i_cfg_data;
                CFG_FALL_STEP:  r_cfg.fall_step <= i_cfg_data[FALL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    avrb_front #(
        .LED_COUNT   (LED_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_sample      (i_sample),
        .i_cfg         (r_cfg),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_push_height (w_push_height)
    );

    avrb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_height (w_push_height),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_stat   (w_q_stat)
    );

    avrb_back #(
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_stat     (w_q_stat),
        .i_height     (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_led_index  (o_led_index),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_bar_height (o_bar_height),
        .o_last       (o_last)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("front took a second sample while busy");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_led_index == IDX_W'(LED_COUNT - 1))))
        else $error("last flag not on final LED");

    a_dark_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (HGT_W'(o_led_index) >= o_bar_height))
            |-> (o_red == '0 && o_green == '0 && o_blue == '0))
        else $error("LED above bar is lit");

    a_height_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bar_height <= HGT_W'(LED_COUNT)))
        else $error("bar height beyond LED count");

    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty) && !(w_push && w_q_stat.full))
        else $error("height queue overrun");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the audio VU rainbow bar meter.
// It predicts every LED result of each sample, drives samples and register writes
// with random idling on both sides, and checks each result. Depends on avrb_pkg.
`timescale 1ns / 100ps

module tb_top;
    import avrb_pkg::*;

    localparam int LED_COUNT = 64;
    localparam int SAMPLE_BITS = 12;
    localparam int HOLD_CYCLES = 600;
    localparam int IDLE_GUARD = 16;
    localparam int MAX_PRINTS = 30;

    typedef struct packed {
        logic [IDX_W-1:0] led_index;
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
        logic [HGT_W-1:0] bar_height;
        logic             last;
    } t_led_result;

    class t_led_scoreboard;
        int unsigned baseline;
        int unsigned threshold;
        int unsigned full_scale;
        int unsigned fall_step;
        int unsigned smoothed;
        int unsigned height;
        int unsigned peak;
        int unsigned samples;
        int unsigned leds_checked;
        int unsigned reg_writes;
        int unsigned errors;
        t_led_result pending_leds[$];

        function new();
            baseline = BASELINE_RST;
            threshold = THRESHOLD_RST;
            full_scale = FULL_SCALE_RST;
            fall_step = FALL_STEP_RST;
            smoothed = 0;
            height = 0;
            peak = 0;
            samples = 0;
            leds_checked = 0;
            reg_writes = 0;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_BASELINE: baseline = data;
                CFG_THRESHOLD: threshold = data;
                CFG_FULL_SCALE: full_scale = data;
                CFG_FALL_STEP: fall_step = data[FALL_W-1:0];
                default: ;
            endcase
            reg_writes++;
        endfunction

        function void rainbow(int unsigned pos, output int unsigned r, output int unsigned g,
                              output int unsigned b);
            int unsigned p;
            p = 255 - (pos & 255);
            if (p < 85) begin
                r = 255 - p * 3;
                g = 0;
                b = p * 3;
            end else if (p < 170) begin
                p = p - 85;
                r = 0;
                g = p * 3;
                b = 255 - p * 3;
            end else begin
                p = p - 170;
                r = p * 3;
                g = 255 - p * 3;
                b = 0;
            end
        endfunction

        function void note_sample(logic [SAMPLE_BITS-1:0] s);
            int unsigned raw;
            int unsigned amp;
            int unsigned fs;
            int unsigned level;
            int unsigned lit;
            int unsigned r;
            int unsigned g;
            int unsigned b;
            t_led_result e;
            raw = s;
            amp = (raw >= baseline) ? raw - baseline : baseline - raw;
            fs = (full_scale == 0) ? 1 : full_scale;
            smoothed = (smoothed * 3 + amp) >> 2;
            level = (smoothed > threshold) ? smoothed - threshold : 0;
            lit = level * LED_COUNT / fs;
            if (lit > LED_COUNT)
                lit = LED_COUNT;
            if (lit > height)
                height = lit;
            else if (height > fall_step)
                height = height - fall_step;
            else
                height = 0;
            for (int i = 0; i < LED_COUNT; i++) begin
                r = 0;
                g = 0;
                b = 0;
                if (i < height)
                    rainbow(i * 255 / (LED_COUNT - 1), r, g, b);
                e.led_index = IDX_W'(i);
                e.red = COL_W'(r);
                e.green = COL_W'(g);
                e.blue = COL_W'(b);
                e.bar_height = HGT_W'(height);
                e.last = (i == LED_COUNT - 1);
                pending_leds.push_back(e);
            end
            if (height > peak)
                peak = height;
            samples++;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task check_led(t_led_result got);
            t_led_result want;
            if (pending_leds.size() == 0) begin
                report($sformatf("LED %0d arrived with no result pending", got.led_index));
                return;
            end
            want = pending_leds.pop_front();
            leds_checked++;
            if (got.led_index !== want.led_index)
                report($sformatf("led_index got %0d want %0d", got.led_index, want.led_index));
            if (got.red !== want.red)
                report($sformatf("LED %0d red got %0d want %0d", want.led_index, got.red,
                                 want.red));
            if (got.green !== want.green)
                report($sformatf("LED %0d green got %0d want %0d", want.led_index, got.green,
                                 want.green));
            if (got.blue !== want.blue)
                report($sformatf("LED %0d blue got %0d want %0d", want.led_index, got.blue,
                                 want.blue));
            if (got.bar_height !== want.bar_height)
                report($sformatf("LED %0d bar_height got %0d want %0d", want.led_index,
                                 got.bar_height, want.bar_height));
            if (got.last !== want.last)
                report($sformatf("LED %0d last got %0b want %0b", want.led_index, got.last,
                                 want.last));
        endtask

        task drain_check();
            if (pending_leds.size() != 0)
                report($sformatf("%0d LED results never arrived", pending_leds.size()));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [SAMPLE_BITS-1:0] i_sample;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    t_cfg_idx               i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [IDX_W-1:0]       o_led_index;
    logic [COL_W-1:0]       o_red;
    logic [COL_W-1:0]       o_green;
    logic [COL_W-1:0]       o_blue;
    logic [HGT_W-1:0]       o_bar_height;
    logic                   o_last;

    t_led_scoreboard     sb;
    bit                  no_idle;
    bit                  hold_req;
    int unsigned         burst_left;
    bit                  burst_loud;
    int unsigned         in_stall_cycles;

    audio_vu_rainbow_bar_top #(
        .LED_COUNT(LED_COUNT),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sample(i_sample),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_led_index(o_led_index),
        .o_red(o_red),
        .o_green(o_green),
        .o_blue(o_blue),
        .o_bar_height(o_bar_height),
        .o_last(o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("Timeout with %0d LED results still pending", sb.pending_leds.size());
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] next_sample(int unsigned base);
        int unsigned amp;
        int          v;
        if ($urandom_range(0, 99) < 15)
            return SAMPLE_BITS'($urandom_range(0, 4095));
        if (burst_left == 0) begin
            burst_loud = 1'($urandom_range(0, 1));
            burst_left = $urandom_range(1, 6);
        end
        burst_left--;
        amp = burst_loud ? $urandom_range(200, 2047) : $urandom_range(0, 40);
        v = $urandom_range(0, 1) ? int'(base) + int'(amp) : int'(base) - int'(amp);
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return SAMPLE_BITS'(v);
    endfunction

    always @(posedge i_clk) begin
        t_led_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.led_index = o_led_index;
            got.red = o_red;
            got.green = o_green;
            got.blue = o_blue;
            got.bar_height = o_bar_height;
            got.last = o_last;
            sb.check_led(got);
        end
        if (i_rst_n && i_in_valid && o_in_stall)
            in_stall_cycles++;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int unsigned run_len;
        int unsigned stall_len;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            run_len = $urandom_range(1, 8);
            stall_len = pick_gap();
            repeat (run_len) @(posedge i_clk);
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    task send_sample(input logic [SAMPLE_BITS-1:0] s);
        int unsigned gap;
        i_sample <= s;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(s);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_leds.size() != 0);
        repeat (IDLE_GUARD) @(posedge i_clk);
    endtask

    task cfg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task set_config(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] thr,
                    input logic [CFG_W-1:0] fs, input logic [CFG_W-1:0] fall);
        cfg_write(CFG_BASELINE, base);
        cfg_write(CFG_THRESHOLD, thr);
        cfg_write(CFG_FULL_SCALE, fs);
        cfg_write(CFG_FALL_STEP, fall);
        i_cfg_valid <= 1'b0;
    endtask

    task random_config();
        logic [CFG_W-1:0] base;
        logic [CFG_W-1:0] thr;
        logic [CFG_W-1:0] fs;
        logic [CFG_W-1:0] fall;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0: base = '0;
                1: base = '1;
                default: base = CFG_W'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 2))
                0: thr = '0;
                1: thr = '1;
                default: thr = CFG_W'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 3))
                0: fs = '0;
                1: fs = 12'd1;
                2: fs = '1;
                default: fs = CFG_W'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 2))
                0: fall = '0;
                1: fall = 12'd64;
                default: fall = CFG_W'($urandom_range(0, 4095));
            endcase
        end else begin
            base = CFG_W'($urandom_range(1800, 2300));
            thr = CFG_W'($urandom_range(0, 150));
            fs = CFG_W'($urandom_range(64, 1500));
            fall = CFG_W'($urandom_range(1, 6));
        end
        set_config(base, thr, fs, fall);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_sample <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_BASELINE;
        i_cfg_data <= '0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        burst_left = 0;
        burst_loud = 1'b0;
        in_stall_cycles = 0;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: extremes, ramp to full bar, fall back
        send_sample('0);
        send_sample('1);
        repeat (5) send_sample('1);
        repeat (4) send_sample(12'd2048);

        // zero full scale and zero fall step: bar holds
        wait_idle();
        set_config('0, '0, '0, '0);
        send_sample(12'd1);
        send_sample('1);
        send_sample('0);
        send_sample('0);

        // fall step wider than the bar
        wait_idle();
        set_config('1, '0, '1, '1);
        send_sample('0);
        send_sample('1);

        // fall step equal to a full bar, then top threshold
        wait_idle();
        set_config(12'd2048, '0, 12'd1, 12'd64);
        send_sample('1);
        wait_idle();
        set_config(12'd2048, '1, 12'd1, 12'd64);
        send_sample(12'd2048);
        send_sample('0);
        wait_idle();
        set_config(12'h555, 12'h0AA, 12'hAAA, 12'd3);
        send_sample(12'h555);
        send_sample(12'hAAA);

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            random_config();
            no_idle = (ph == 3);
            if (ph == 1)
                hold_req = 1'b1;
            for (int k = 0; k < 25; k++) begin
                if (ph == 4 && k == 12)
                    wait_idle();
                send_sample(next_sample(sb.baseline));
            end
        end
        no_idle = 1'b0;

        wait_idle();
        repeat (80) @(posedge i_clk);
        sb.drain_check();
        $display("Ran %0d samples through %0d register writes; checked %0d LED results.",
                 sb.samples, sb.reg_writes, sb.leds_checked);
        $display("Peak bar height %0d; input held off for %0d cycles.", sb.peak,
                 in_stall_cycles);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
